/* rtl/fpd_pkg.sv */
// ----------------------------------------------------------------------------
// Flagged packet deframer package
// Field widths, opcodes, register indexes and framing phase codes.
// ----------------------------------------------------------------------------
package fpd_pkg;

   // Field widths of the request and response transfers.
   localparam int OPCODE_W     = 2;
   localparam int BYTE_W       = 8;
   localparam int READ_INDEX_W = 6;
   localparam int PHASE_W      = 2;
   localparam int LENGTH_W     = 7;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   typedef logic [OPCODE_W-1:0]    opcode_type;
   typedef logic [BYTE_W-1:0]      byte_type;
   typedef logic [READ_INDEX_W-1:0] read_index_type;
   typedef logic [PHASE_W-1:0]     phase_type;
   typedef logic [LENGTH_W-1:0]    length_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // Request opcodes.
   localparam opcode_type OP_BYTE    = 2'd0;
   localparam opcode_type OP_READ    = 2'd1;
   localparam opcode_type OP_RELEASE = 2'd2;

   // Register indexes.
   localparam csr_index_type CSR_FLAG_BYTE   = 2'd0;
   localparam csr_index_type CSR_FLAG_RUN    = 2'd1;
   localparam csr_index_type CSR_MAX_PAYLOAD = 2'd2;

   // Register reset values.
   localparam byte_type   FLAG_BYTE_RST   = 8'd126;
   localparam byte_type   FLAG_RUN_RST    = 8'd3;
   localparam length_type MAX_PAYLOAD_RST = 7'd64;

   // Framing phases.
   localparam phase_type PH_HUNT = 2'd0;
   localparam phase_type PH_LEN  = 2'd1;
   localparam phase_type PH_DATA = 2'd2;
   localparam phase_type PH_DONE = 2'd3;

endpackage

/* rtl/fpd_req_if.sv */
// ----------------------------------------------------------------------------
// Deframer request channel
// Valid/ready channel that carries one request item per transfer.
// ----------------------------------------------------------------------------
interface fpd_req_if;
   import fpd_pkg::*;

   logic           valid;
   logic           ready;
   opcode_type     opcode;
   byte_type       rx_byte;
   read_index_type read_index;

   modport source (output valid, output opcode, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input opcode, input rx_byte, input read_index,
                   output ready);
endinterface

/* rtl/fpd_rsp_if.sv */
// ----------------------------------------------------------------------------
// Deframer response channel
// Valid/ready channel that carries one status item per transfer.
// ----------------------------------------------------------------------------
interface fpd_rsp_if;
   import fpd_pkg::*;

   logic       valid;
   logic       ready;
   byte_type   read_data;
   phase_type  frame_phase;
   logic       packet_ready;
   length_type payload_length;
   logic       byte_stored;

   modport source (output valid, output read_data, output frame_phase,
                   output packet_ready, output payload_length, output byte_stored,
                   input ready);
   modport sink   (input valid, input read_data, input frame_phase,
                   input packet_ready, input payload_length, input byte_stored,
                   output ready);
endinterface

/* rtl/fpd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/flagged_packet_deframer.sv */
// ----------------------------------------------------------------------------
// Flagged packet deframer
// A request transfer gives its response from the response register in the next cycle.
// Throughput: one request per cycle while rsp_chan is not stalled (response register).
// Reset (synchronous, active high) returns framing to header hunt and the registers
// to flag 126, run length 3, max payload 64; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module flagged_packet_deframer #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  fpd_pkg::csr_index_type csr_index,
   input  fpd_pkg::csr_data_type  csr_wdata,
   fpd_req_if.sink                req_chan,
   fpd_rsp_if.source              rsp_chan
);
   import fpd_pkg::*;

   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int FILL_W = (ADDR_W > LENGTH_W) ? ADDR_W : LENGTH_W;
   localparam int RIDX_W = (ADDR_W > READ_INDEX_W) ? ADDR_W : READ_INDEX_W;
   localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);

   // Configuration registers.
   byte_type   flag_byte_ff, flag_byte_in;
   byte_type   flag_run_ff, flag_run_in;
   length_type max_payload_ff, max_payload_in;

   // Framing state.
   phase_type  phase_ff, phase_in;
   byte_type   flag_count_ff, flag_count_in;
   length_type fill_index_ff, fill_index_in;
   length_type exp_length_ff, exp_length_in;
   byte_type   payload_sum_ff, payload_sum_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rd_sel_ff, rd_sel_in;
   phase_type  rsp_phase_ff;
   logic       rsp_ready_pulse_ff, ready_pulse;
   length_type rsp_length_ff, rsp_length_in;
   logic       rsp_stored_ff, stored;

   logic              take;
   byte_type          rx;
   byte_type          count_next;
   logic [7:0]        max_ext;
   logic [7:0]        limit;
   logic              wr_en;
   logic              rd_en;
   logic [FILL_W-1:0] fill_wide;
   logic [RIDX_W-1:0] ridx_wide;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   byte_type          ram_rdata;

   assign take = req_chan.valid && req_chan.ready;
   assign rx   = req_chan.rx_byte;

   // A new request is taken whenever the response register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   // Configuration writes; an index past the list is ignored.
   always_comb begin
      flag_byte_in   = flag_byte_ff;
      flag_run_in    = flag_run_ff;
      max_payload_in = max_payload_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FLAG_BYTE:   flag_byte_in   = csr_wdata;
            CSR_FLAG_RUN:    flag_run_in    = csr_wdata;
            CSR_MAX_PAYLOAD: max_payload_in = csr_wdata[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   // The accepted length is capped by both max_payload and the buffer depth.
   assign max_ext    = {1'b0, max_payload_ff};
   assign limit      = (max_ext > DEPTH_B) ? DEPTH_B : max_ext;
   assign count_next = (rx == flag_byte_ff) ? flag_count_ff + 8'd1 : 8'd0;

   // Framing update for one request.
   always_comb begin
      phase_in       = phase_ff;
      flag_count_in  = flag_count_ff;
      fill_index_in  = fill_index_ff;
      exp_length_in  = exp_length_ff;
      payload_sum_in = payload_sum_ff;
      ready_pulse    = 1'b0;
      stored         = 1'b0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_sel_in      = 1'b0;
      if (take) begin
         unique case (req_chan.opcode)
            OP_BYTE: begin
               flag_count_in = count_next;
               // A completed flag run wins over all other byte handling unless in PH_DONE.
               priority if (count_next == flag_run_ff && phase_ff != PH_DONE) begin
                  phase_in       = PH_LEN;
                  payload_sum_in = '0;
               end else if (phase_ff == PH_LEN && rx <= limit) begin
                  phase_in      = PH_DATA;
                  fill_index_in = '0;
                  exp_length_in = rx[LENGTH_W-1:0];
               end else if (phase_ff == PH_DATA && fill_index_ff < exp_length_ff) begin
                  if ({1'b0, fill_index_ff} < DEPTH_B) begin
                     wr_en  = 1'b1;
                     stored = 1'b1;
                  end
                  fill_index_in  = fill_index_ff + 7'd1;
                  payload_sum_in = payload_sum_ff + rx;
               end else if (phase_ff == PH_DATA && fill_index_ff == exp_length_ff
                            && payload_sum_ff == ~rx) begin
                  phase_in    = PH_DONE;
                  ready_pulse = 1'b1;
               end else if (phase_ff != PH_DONE) begin
                  phase_in = PH_HUNT;
               end else begin
                  phase_in = phase_ff;
               end
            end
            OP_READ: begin
               // Reads beyond the buffer return zero without a RAM access.
               if ({2'b00, req_chan.read_index} < DEPTH_B) begin
                  rd_en     = 1'b1;
                  rd_sel_in = 1'b1;
               end
            end
            OP_RELEASE: begin
               if (phase_ff == PH_DONE) begin
                  phase_in = PH_HUNT;
               end
            end
            default: ;
         endcase
      end
   end

   // Buffer addresses sized to the depth.
   assign fill_wide = FILL_W'(fill_index_ff);
   assign ridx_wide = RIDX_W'(req_chan.read_index);
   assign wr_addr   = fill_wide[ADDR_W-1:0];
   assign rd_addr   = ridx_wide[ADDR_W-1:0];

   fpd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Response register handshake.
   assign rsp_length_in = (phase_in == PH_DATA || phase_in == PH_DONE) ? exp_length_in : '0;
   assign rsp_valid_in  = take ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_byte_ff   <= FLAG_BYTE_RST;
         flag_run_ff    <= FLAG_RUN_RST;
         max_payload_ff <= MAX_PAYLOAD_RST;
         phase_ff       <= PH_HUNT;
         flag_count_ff  <= '0;
         fill_index_ff  <= '0;
         exp_length_ff  <= '0;
         payload_sum_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         flag_byte_ff   <= flag_byte_in;
         flag_run_ff    <= flag_run_in;
         max_payload_ff <= max_payload_in;
         phase_ff       <= phase_in;
         flag_count_ff  <= flag_count_in;
         fill_index_ff  <= fill_index_in;
         exp_length_ff  <= exp_length_in;
         payload_sum_ff <= payload_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Response payload, loaded on each request transfer.
   always_ff @(posedge clock) begin
      if (take) begin
         rd_sel_ff          <= rd_sel_in;
         rsp_phase_ff       <= phase_in;
         rsp_ready_pulse_ff <= ready_pulse;
         rsp_length_ff      <= rsp_length_in;
         rsp_stored_ff      <= stored;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_data      = rd_sel_ff ? ram_rdata : '0;
   assign rsp_chan.frame_phase    = rsp_phase_ff;
   assign rsp_chan.packet_ready   = rsp_ready_pulse_ff;
   assign rsp_chan.payload_length = rsp_length_ff;
   assign rsp_chan.byte_stored    = rsp_stored_ff;

`ifndef SYNTHESIS
   // A verified packet is reported together with the verified phase.
   a_ready_in_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready_pulse_ff |-> rsp_phase_ff == PH_DONE)
      else $error("packet_ready outside verified phase");

   // Buffer writes happen only while collecting payload.
   a_store_in_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stored_ff |-> rsp_phase_ff == PH_DATA)
      else $error("byte stored outside payload phase");

   // The fill index never runs past the expected length.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> fill_index_ff <= exp_length_ff)
      else $error("fill index beyond expected length");

   // An accepted length always fits the buffer.
   a_length_fits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_DONE) |-> {1'b0, exp_length_ff} <= DEPTH_B)
      else $error("expected length exceeds buffer depth");

   // A write and a read never share a cycle.
   a_one_port_use: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("buffer write and read in one cycle");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flagged packet deframer testbench
// Drives request transfers through the valid/ready channel. A scoreboard
// predicts each status response from its own copy of the framing state,
// buffer and registers, and then compares every response field by field.
// The stimulus is a short directed sequence followed by random packets,
// damaged packets and noise, run under several register settings and
// several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import fpd_pkg::*;

   localparam int DEPTH       = 64;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 25;

   // Opcode that the block ignores apart from reporting status.
   localparam opcode_type OP_UNUSED = 2'd3;

   // One status response of the block.
   typedef struct {
      byte_type   read_data;
      phase_type  frame_phase;
      logic       packet_ready;
      length_type payload_length;
      logic       byte_stored;
   } status_type;

   // Ways in which a random packet is damaged.
   typedef enum int {CLEAN, BAD_CHECK, TOO_LONG, RESTART, TRUNCATED} damage_type;

   // Framing predictor and store of expected status responses.
   class deframer_scoreboard;
      byte_type   flag_byte;
      byte_type   flag_run;
      length_type max_payload;
      phase_type  phase;
      byte_type   flag_count;
      length_type fill_index;
      length_type expected_length;
      byte_type   payload_sum;
      byte_type   store [DEPTH];
      bit         written [DEPTH];
      status_type expected_status [$];
      int         errors;

      function new();
         flag_byte       = FLAG_BYTE_RST;
         flag_run        = FLAG_RUN_RST;
         max_payload     = MAX_PAYLOAD_RST;
         phase           = PH_HUNT;
         flag_count      = '0;
         fill_index      = '0;
         expected_length = '0;
         payload_sum     = '0;
         foreach (written[i]) written[i] = 1'b0;
         errors = 0;
      endfunction

      // Advance the framing state by one accepted request and queue its status.
      function void note_request(opcode_type op, byte_type rx, read_index_type idx);
         status_type st;
         int         limit;
         byte_type   inverted;
         st.read_data    = '0;
         st.packet_ready = 1'b0;
         st.byte_stored  = 1'b0;
         limit    = (max_payload > DEPTH) ? DEPTH : max_payload;
         inverted = ~rx;
         if (op == OP_BYTE) begin
            // Every received byte updates the flag run counter.
            if (rx == flag_byte) flag_count = flag_count + 8'd1;
            else flag_count = '0;
            if (flag_count == flag_run && phase != PH_DONE) begin
               phase       = PH_LEN;
               payload_sum = '0;
            end else if (phase == PH_LEN && rx <= limit) begin
               phase           = PH_DATA;
               fill_index      = '0;
               expected_length = rx[LENGTH_W-1:0];
            end else if (phase == PH_DATA && fill_index < expected_length) begin
               if (fill_index < DEPTH) begin
                  store[fill_index]   = rx;
                  written[fill_index] = 1'b1;
                  st.byte_stored      = 1'b1;
               end
               fill_index  = fill_index + 7'd1;
               payload_sum = payload_sum + rx;
            end else if (phase == PH_DATA && fill_index == expected_length &&
                         payload_sum == inverted) begin
               phase           = PH_DONE;
               st.packet_ready = 1'b1;
            end else if (phase != PH_DONE) begin
               phase = PH_HUNT;
            end
         end else if (op == OP_READ) begin
            st.read_data = store[idx];
         end else if (op == OP_RELEASE) begin
            if (phase == PH_DONE) phase = PH_HUNT;
         end
         st.frame_phase    = phase;
         st.payload_length = (phase == PH_DATA || phase == PH_DONE) ? expected_length : '0;
         expected_status.push_back(st);
      endfunction

      // Compare one response transfer with the oldest expected status.
      function void check_status(status_type got);
         status_type want;
         if (expected_status.size() == 0) begin
            $error("response transfer with no expected status");
            errors++;
            return;
         end
         want = expected_status.pop_front();
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0d, actual %0d", want.read_data, got.read_data);
            errors++;
         end
         if (got.frame_phase !== want.frame_phase) begin
            $error("frame_phase: expected %0d, actual %0d", want.frame_phase, got.frame_phase);
            errors++;
         end
         if (got.packet_ready !== want.packet_ready) begin
            $error("packet_ready: expected %0d, actual %0d", want.packet_ready,
                   got.packet_ready);
            errors++;
         end
         if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, actual %0d", want.payload_length,
                   got.payload_length);
            errors++;
         end
         if (got.byte_stored !== want.byte_stored) begin
            $error("byte_stored: expected %0d, actual %0d", want.byte_stored, got.byte_stored);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_status.size();
      endfunction

      // A buffer entry that has been written, or -1 while none has.
      function int pick_written_index();
         int start;
         start = $urandom_range(0, DEPTH - 1);
         for (int k = 0; k < DEPTH; k++) begin
            if (written[(start + k) % DEPTH]) return (start + k) % DEPTH;
         end
         return -1;
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   fpd_req_if req_chan ();
   fpd_rsp_if rsp_chan ();

   deframer_scoreboard sb = new();

   int send_idle_pct;
   int recv_stall_pct;
   int hold_request;
   int sent_count;

   flagged_packet_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #2 clock = ~clock;

   function automatic byte_type any_byte();
      return byte_type'($urandom);
   endfunction

   function automatic read_index_type any_index();
      return read_index_type'($urandom);
   endfunction

   function automatic int payload_limit();
      return (sb.max_payload > DEPTH) ? DEPTH : sb.max_payload;
   endfunction

   // Offer one request, with random idle cycles first, and wait for its transfer.
   task automatic send_item(opcode_type op, byte_type rx, read_index_type idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.rx_byte    <= rx;
      req_chan.read_index <= idx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(op, rx, idx);
      if (op != OP_UNUSED) sent_count++;
   endtask

   // Read back a buffer entry that holds payload data.
   task automatic send_read();
      int idx;
      idx = sb.pick_written_index();
      if (idx >= 0) send_item(OP_READ, any_byte(), read_index_type'(idx));
   endtask

   // Stop offering requests and wait until every expected status has arrived.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write all three registers while the block is idle.
   task automatic configure(byte_type flag, byte_type run, length_type max_len);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_FLAG_BYTE;
      csr_wdata <= flag;
      @(posedge clock);
      csr_index <= CSR_FLAG_RUN;
      csr_wdata <= run;
      @(posedge clock);
      csr_index <= CSR_MAX_PAYLOAD;
      csr_wdata <= csr_data_type'(max_len);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.flag_byte   = flag;
      sb.flag_run    = run;
      sb.max_payload = max_len;
   endtask

   // Flag run, length, payload and check byte, with optional damage.
   task automatic send_packet(int len, damage_type damage);
      byte_type sum;
      byte_type data;
      int       limit;
      int       cut;
      limit = payload_limit();
      repeat (sb.flag_run) send_item(OP_BYTE, sb.flag_byte, any_index());
      if (damage == TOO_LONG) begin
         send_item(OP_BYTE, byte_type'($urandom_range(limit + 1, 255)), any_index());
         return;
      end
      send_item(OP_BYTE, byte_type'(len), any_index());
      cut = (damage == RESTART || damage == TRUNCATED) ? $urandom_range(0, len) : len + 1;
      sum = '0;
      for (int i = 0; i < len && i != cut; i++) begin
         // Keep flags out of the payload so that clean packets usually verify.
         data = any_byte();
         if (data == sb.flag_byte) data = data ^ 8'h01;
         sum = sum + data;
         send_item(OP_BYTE, data, any_index());
      end
      if (damage == RESTART) begin
         send_packet(len, CLEAN);
         return;
      end
      if (damage == TRUNCATED) return;
      if (damage == BAD_CHECK) send_item(OP_BYTE, ~sum ^ byte_type'($urandom_range(1, 255)),
                                         any_index());
      else send_item(OP_BYTE, ~sum, any_index());
   endtask

   // Mostly packets followed by read-back and release; the rest is noise.
   task automatic random_sequence();
      int         pick;
      int         limit;
      int         len;
      damage_type damage;
      limit = payload_limit();
      pick  = $urandom_range(0, 99);
      if (pick < 70) begin
         if ($urandom_range(0, 9) == 0) len = $urandom_range(0, limit);
         else len = $urandom_range(0, (limit < 8) ? limit : 8);
         if ($urandom_range(0, 4) == 0)
            damage = damage_type'($urandom_range(int'(BAD_CHECK), int'(TRUNCATED)));
         else damage = CLEAN;
         send_packet(len, damage);
         repeat ($urandom_range(0, 3)) send_read();
         if ($urandom_range(0, 9) != 0) send_item(OP_RELEASE, any_byte(), any_index());
      end else if (pick < 82) begin
         send_item(OP_BYTE, ($urandom_range(0, 1) == 0) ? sb.flag_byte : any_byte(),
                   any_index());
      end else if (pick < 90) begin
         send_read();
      end else if (pick < 96) begin
         send_item(OP_RELEASE, any_byte(), any_index());
      end else begin
         send_item(OP_UNUSED, any_byte(), any_index());
      end
   endtask

   task automatic random_phase(int items);
      int target;
      target = sent_count + items;
      while (sent_count < target) random_sequence();
   endtask

   // Response side: check each transfer, then choose ready for the next cycle.
   initial begin : response_side
      int         hold_left;
      status_type got;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.read_data      = rsp_chan.read_data;
            got.frame_phase    = rsp_chan.frame_phase;
            got.packet_ready   = rsp_chan.packet_ready;
            got.payload_length = rsp_chan.payload_length;
            got.byte_stored    = rsp_chan.byte_stored;
            sb.check_status(got);
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: too many cycles without a transfer on either channel.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else quiet++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_FLAG_BYTE;
      csr_wdata           = '0;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = OP_BYTE;
      req_chan.rx_byte    = '0;
      req_chan.read_index = '0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      hold_request        = 0;
      sent_count          = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      send_item(OP_UNUSED, 8'hA5, 6'h2A);
      send_item(OP_RELEASE, 8'h5A, 6'h15);
      // Good packet carrying both extreme byte values.
      repeat (3) send_item(OP_BYTE, FLAG_BYTE_RST, '0);
      send_item(OP_BYTE, 8'd2, '1);
      send_item(OP_BYTE, 8'h00, '1);
      send_item(OP_BYTE, 8'hFF, '0);
      send_item(OP_BYTE, 8'h00, '0);
      // While verified, a full flag run only advances the counter.
      repeat (3) send_item(OP_BYTE, FLAG_BYTE_RST, '0);
      send_item(OP_READ, 8'hFF, 6'd0);
      send_item(OP_READ, 8'h00, 6'd1);
      send_item(OP_RELEASE, 8'h00, '0);
      send_item(OP_BYTE, 8'hFF, '0);
      // Length one above the limit goes back to header hunt.
      repeat (3) send_item(OP_BYTE, FLAG_BYTE_RST, '0);
      send_item(OP_BYTE, 8'd65, '0);
      // A flag run in mid-payload restarts framing, then a bad check on length zero.
      repeat (3) send_item(OP_BYTE, FLAG_BYTE_RST, '0);
      send_item(OP_BYTE, 8'd1, '0);
      repeat (3) send_item(OP_BYTE, FLAG_BYTE_RST, '0);
      send_item(OP_BYTE, 8'd0, '0);
      send_item(OP_BYTE, 8'h00, '0);

      // No idling, with one long receiver hold-off that backs up the input.
      configure(any_byte(), 8'd3, 7'd64);
      hold_request = HOLD_CYCLES;
      random_phase(PHASE_ITEMS);

      // Run length one, sender mostly idle; a long run wraps the flag counter.
      configure(any_byte(), 8'd1, 7'd64);
      send_idle_pct = 76;
      send_item(OP_BYTE, ~sb.flag_byte, any_index());
      repeat (257) send_item(OP_BYTE, sb.flag_byte, any_index());
      random_phase(PHASE_ITEMS);

      // Lowest flag value and zero payload limit, receiver mostly stalled.
      configure(8'h00, 8'd2, 7'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 76;
      random_phase(PHASE_ITEMS);

      // Highest flag value and a small limit, both sides idling.
      configure(8'hFF, 8'd4, length_type'($urandom_range(1, 63)));
      send_idle_pct  = 30;
      recv_stall_pct = 30;
      random_phase(PHASE_ITEMS);

      // Zero run length matches on every non-flag byte.
      configure(any_byte(), 8'd0, 7'd8);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_phase(30);

      drain();
      repeat (4) @(posedge clock);
      if (sb.errors == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

endmodule
